// File: hw/rtl/assert_macros.svh
// assertion macros included by piecewise_linear_contrast_stretch.sv
// the synthesis view gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// clocked assertion that also holds across reset
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif

`endif

// File: hw/rtl/pwlcs_pkg.sv
package pwlcs_pkg;

   // pixel levels
   localparam int LEVEL_W = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

   // knee points: register pairs in the map and the design limit
   localparam int KNEE_REGS = 3;
   localparam int MAX_KNEES = 3;
   localparam int KNEE_LIMIT = (MAX_KNEES < KNEE_REGS) ? MAX_KNEES : KNEE_REGS;
   localparam logic [1:0] KNEE_LIMIT_W = 2'(KNEE_LIMIT);

   // register map, one 32-bit word per register
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_KNEE_COUNT = 3'd0,
      REG_KNEE0_IN   = 3'd1,
      REG_KNEE0_OUT  = 3'd2,
      REG_KNEE1_IN   = 3'd3,
      REG_KNEE1_OUT  = 3'd4,
      REG_KNEE2_IN   = 3'd5,
      REG_KNEE2_OUT  = 3'd6
   } csr_index_type;

   // product of two level differences and the quotient width
   localparam int PROD_W = 2 * LEVEL_W;
   localparam int DIV_BITS = PROD_W;

   // pipeline stage positions
   localparam int ST_SEL     = 0;
   localparam int ST_DIFF    = 1;
   localparam int ST_MUL     = 2;
   localparam int ST_DIV0    = 3;
   localparam int ST_RND     = ST_DIV0 + DIV_BITS;
   localparam int ST_OUT     = ST_RND + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   // one divider stage: partial remainder, dividend bits shifted out
   // while quotient bits shift in, plus what travels alongside
   typedef struct packed {
      logic [LEVEL_W-1:0] rem;
      logic [PROD_W-1:0]  work;
      logic [LEVEL_W-1:0] den;
      logic               neg;
      logic               zero;
      logic [LEVEL_W-1:0] lvl_a;
   } div_type;

endpackage

// File: hw/rtl/piecewise_linear_contrast_stretch.sv
// channel | direction | handshake               | payload
// req     | in        | req_valid / req_ready   | req_gray_in[7:0]
// rsp     | out       | rsp_valid / rsp_ready   | rsp_gray_out[7:0]
// csr     | in / out  | psel, penable, pready   | paddr[4:0], pwdata, prdata
//
// one pixel per clock sustained while the skid buffer is empty
// the restoring divider fills most of the pipeline, one quotient bit per stage (16)
// reset is synchronous and clears all valid bits and restores the knee registers
// a one-entry skid buffer at the output lets the pipeline take a transaction
// in the cycle the output stalls; the pipeline halts only while the skid is full
`include "assert_macros.svh"

module piecewise_linear_contrast_stretch
   import pwlcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVEL_W-1:0]    req_gray_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_gray_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // knee registers
   logic [1:0]         knee_count_ff;
   logic [LEVEL_W-1:0] knee_in_ff  [KNEE_REGS];
   logic [LEVEL_W-1:0] knee_out_ff [KNEE_REGS];
   csr_index_type      csr_idx;
   logic               csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_count_ff  <= 2'd1;
         knee_in_ff[0]  <= 8'd128;
         knee_out_ff[0] <= 8'd128;
         knee_in_ff[1]  <= 8'd192;
         knee_out_ff[1] <= 8'd192;
         knee_in_ff[2]  <= 8'd224;
         knee_out_ff[2] <= 8'd224;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KNEE_COUNT: knee_count_ff  <= pwdata[1:0];
            REG_KNEE0_IN:   knee_in_ff[0]  <= pwdata[LEVEL_W-1:0];
            REG_KNEE0_OUT:  knee_out_ff[0] <= pwdata[LEVEL_W-1:0];
            REG_KNEE1_IN:   knee_in_ff[1]  <= pwdata[LEVEL_W-1:0];
            REG_KNEE1_OUT:  knee_out_ff[1] <= pwdata[LEVEL_W-1:0];
            REG_KNEE2_IN:   knee_in_ff[2]  <= pwdata[LEVEL_W-1:0];
            REG_KNEE2_OUT:  knee_out_ff[2] <= pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_KNEE_COUNT: prdata = {30'b0, knee_count_ff};
         REG_KNEE0_IN:   prdata = {24'b0, knee_in_ff[0]};
         REG_KNEE0_OUT:  prdata = {24'b0, knee_out_ff[0]};
         REG_KNEE1_IN:   prdata = {24'b0, knee_in_ff[1]};
         REG_KNEE1_OUT:  prdata = {24'b0, knee_out_ff[1]};
         REG_KNEE2_IN:   prdata = {24'b0, knee_in_ff[2]};
         REG_KNEE2_OUT:  prdata = {24'b0, knee_out_ff[2]};
         default:        prdata = '0;
      endcase
   end

   // pipeline control: every stage moves while the skid buffer is empty
   logic [NUM_STAGES-1:0] vld_ff;
   logic                  skid_vld_ff;
   logic [LEVEL_W-1:0]    skid_data_ff;
   logic                  pipe_en;

   assign pipe_en   = ~skid_vld_ff;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // active knee count, zero counts as one
   logic [1:0] knee_n;
   always_comb begin
      knee_n = (knee_count_ff == 2'd0) ? 2'd1 : knee_count_ff;
      if (knee_n > KNEE_LIMIT_W) begin
         knee_n = KNEE_LIMIT_W;
      end
   end

   // segment select: first active knee at or above the pixel
   logic [1:0]         seg;
   logic [LEVEL_W-1:0] sel_a_in, sel_b_in, sel_c_in, sel_d_in;
   always_comb begin
      seg = knee_n;
      for (int i = KNEE_REGS - 1; i >= 0; i--) begin
         if ((i < int'(knee_n)) && (req_gray_in <= knee_in_ff[i])) begin
            seg = 2'(i);
         end
      end
      // lower end of the segment
      unique case (seg)
         2'd0: begin
            sel_a_in = '0;
            sel_c_in = '0;
         end
         2'd1: begin
            sel_a_in = knee_out_ff[0];
            sel_c_in = knee_in_ff[0];
         end
         2'd2: begin
            sel_a_in = knee_out_ff[1];
            sel_c_in = knee_in_ff[1];
         end
         default: begin
            sel_a_in = knee_out_ff[2];
            sel_c_in = knee_in_ff[2];
         end
      endcase
      // upper end, full scale past the last knee
      sel_b_in = LEVEL_MAX;
      sel_d_in = LEVEL_MAX;
      if (seg != knee_n) begin
         unique case (seg)
            2'd0: begin
               sel_b_in = knee_out_ff[0];
               sel_d_in = knee_in_ff[0];
            end
            2'd1: begin
               sel_b_in = knee_out_ff[1];
               sel_d_in = knee_in_ff[1];
            end
            2'd2: begin
               sel_b_in = knee_out_ff[2];
               sel_d_in = knee_in_ff[2];
            end
            default: begin
               sel_b_in = LEVEL_MAX;
               sel_d_in = LEVEL_MAX;
            end
         endcase
      end
   end

   logic [LEVEL_W-1:0] sel_p_ff, sel_a_ff, sel_b_ff, sel_c_ff, sel_d_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sel_p_ff <= req_gray_in;
         sel_a_ff <= sel_a_in;
         sel_b_ff <= sel_b_in;
         sel_c_ff <= sel_c_in;
         sel_d_ff <= sel_d_in;
      end
   end

   // signed differences p-c, b-a, d-c
   logic signed [LEVEL_W:0] dif_pc_ff, dif_ba_ff, dif_dc_ff;
   logic [LEVEL_W-1:0]      dif_a_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dif_pc_ff <= $signed({1'b0, sel_p_ff}) - $signed({1'b0, sel_c_ff});
         dif_ba_ff <= $signed({1'b0, sel_b_ff}) - $signed({1'b0, sel_a_ff});
         dif_dc_ff <= $signed({1'b0, sel_d_ff}) - $signed({1'b0, sel_c_ff});
         dif_a_ff  <= sel_a_ff;
      end
   end

   // magnitudes, product and overall sign
   logic [LEVEL_W-1:0] pc_mag, ba_mag, dc_mag;
   assign pc_mag = dif_pc_ff[LEVEL_W] ? LEVEL_W'(-dif_pc_ff) : dif_pc_ff[LEVEL_W-1:0];
   assign ba_mag = dif_ba_ff[LEVEL_W] ? LEVEL_W'(-dif_ba_ff) : dif_ba_ff[LEVEL_W-1:0];
   assign dc_mag = dif_dc_ff[LEVEL_W] ? LEVEL_W'(-dif_dc_ff) : dif_dc_ff[LEVEL_W-1:0];

   logic [PROD_W-1:0]  mul_prod_ff;
   logic [LEVEL_W-1:0] mul_den_ff, mul_a_ff;
   logic               mul_neg_ff, mul_zero_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mul_prod_ff <= PROD_W'(pc_mag) * PROD_W'(ba_mag);
         mul_den_ff  <= dc_mag;
         mul_neg_ff  <= dif_pc_ff[LEVEL_W] ^ dif_ba_ff[LEVEL_W] ^ dif_dc_ff[LEVEL_W];
         mul_zero_ff <= (dif_dc_ff == '0);
         mul_a_ff    <= dif_a_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   div_type div_ff [DIV_BITS];
   div_type div_in [DIV_BITS];
   always_comb begin
      div_type            src;
      logic [LEVEL_W:0]   trial;
      for (int k = 0; k < DIV_BITS; k++) begin
         if (k == 0) begin
            src.rem   = '0;
            src.work  = mul_prod_ff;
            src.den   = mul_den_ff;
            src.neg   = mul_neg_ff;
            src.zero  = mul_zero_ff;
            src.lvl_a = mul_a_ff;
         end else begin
            src = div_ff[k-1];
         end
         trial     = {src.rem, src.work[PROD_W-1]};
         div_in[k] = src;
         if (trial >= {1'b0, src.den}) begin
            div_in[k].rem  = LEVEL_W'(trial - {1'b0, src.den});
            div_in[k].work = {src.work[PROD_W-2:0], 1'b1};
         end else begin
            div_in[k].rem  = trial[LEVEL_W-1:0];
            div_in[k].work = {src.work[PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // round half to even on the magnitude
   div_type            div_last;
   logic [LEVEL_W:0]   twice_rem;
   logic               rnd_up;
   assign div_last  = div_ff[DIV_BITS-1];
   assign twice_rem = {div_last.rem, 1'b0};
   assign rnd_up    = (twice_rem > {1'b0, div_last.den}) ||
                      ((twice_rem == {1'b0, div_last.den}) && div_last.work[0]);

   logic [PROD_W:0]    rnd_q_ff;
   logic [LEVEL_W-1:0] rnd_a_ff;
   logic               rnd_neg_ff, rnd_zero_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rnd_q_ff    <= {1'b0, div_last.work} + (PROD_W + 1)'(rnd_up);
         rnd_a_ff    <= div_last.lvl_a;
         rnd_neg_ff  <= div_last.neg;
         rnd_zero_ff <= div_last.zero;
      end
   end

   // apply the sign, add the segment base and clamp; a zero-width segment gives the base
   logic signed [PROD_W+1:0] q_signed, delta, level_sum;
   logic [LEVEL_W-1:0]       out_in;
   always_comb begin
      q_signed  = $signed({1'b0, rnd_q_ff});
      delta     = rnd_neg_ff ? -q_signed : q_signed;
      level_sum = $signed({{(PROD_W+2-LEVEL_W){1'b0}}, rnd_a_ff}) + delta;
      priority if (rnd_zero_ff) begin
         out_in = rnd_a_ff;
      end else if (level_sum < 0) begin
         out_in = '0;
      end else if (level_sum > $signed({{(PROD_W+2-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
         out_in = LEVEL_MAX;
      end else begin
         out_in = level_sum[LEVEL_W-1:0];
      end
   end

   logic [LEVEL_W-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_ff <= out_in;
      end
   end

   // skid buffer catches the output transaction when the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= ~rsp_ready;
      end else begin
         skid_vld_ff <= vld_ff[ST_OUT] & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_data_ff <= out_ff;
      end
   end

   assign rsp_valid    = skid_vld_ff | vld_ff[ST_OUT];
   assign rsp_gray_out = skid_vld_ff ? skid_data_ff : out_ff;

   // checks
   `ASSERT_CLK_NR(a_reset_clears_rsp, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_skid_freezes_pipe, clock, reset, skid_vld_ff |=> $stable(vld_ff))
   `ASSERT_CLK(a_skid_only_on_stall, clock, reset, $rose(skid_vld_ff) |-> $past(!rsp_ready))
   `ASSERT_CLK(a_div_rem_below_den, clock, reset, vld_ff[ST_RND-1] && !div_last.zero |-> div_last.rem < div_last.den)

endmodule

// File: bench/tb.sv
module tb;
   import pwlcs_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   logic [LEVEL_W-1:0]    req_gray_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [LEVEL_W-1:0]    rsp_gray_out;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // local copy of the transfer curve registers
   logic [1:0]         curve_knees;
   logic [LEVEL_W-1:0] curve_in [KNEE_REGS];
   logic [LEVEL_W-1:0] curve_out [KNEE_REGS];

   // stretched levels still owed by the block, oldest first
   logic [LEVEL_W-1:0] owed_levels [$];
   int                 mismatch_count = 0;
   bit                 send_gaps_on = 1'b1;
   bit                 take_gaps_on = 1'b1;
   int                 hold_off_cycles = 0;

   piecewise_linear_contrast_stretch dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_gray_in  (req_gray_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray_out (rsp_gray_out),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // curve lookup with exact interpolation, ties to even, clamped
   function automatic logic [LEVEL_W-1:0] stretch_level(input logic [LEVEL_W-1:0] pix);
      int     n;
      int     i;
      longint p, a, b, c, d, num, den, q, r, y;
      n = (curve_knees == 2'd0) ? 1 : int'(curve_knees);
      if (n > KNEE_LIMIT) n = KNEE_LIMIT;
      p = longint'(pix);
      i = 0;
      while (i < n && p > longint'(curve_in[i])) i++;
      if (i == n) begin
         a = longint'(curve_out[n-1]);
         c = longint'(curve_in[n-1]);
         b = longint'(LEVEL_MAX);
         d = longint'(LEVEL_MAX);
      end else if (i == 0) begin
         a = 0;
         c = 0;
         b = longint'(curve_out[0]);
         d = longint'(curve_in[0]);
      end else begin
         a = longint'(curve_out[i-1]);
         c = longint'(curve_in[i-1]);
         b = longint'(curve_out[i]);
         d = longint'(curve_in[i]);
      end
      den = d - c;
      if (den == 0) begin
         y = a;
      end else begin
         num = (p - c) * (b - a);
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         // floor division, then round half to even
         q = num / den;
         r = num % den;
         if (r < 0) begin
            q = q - 1;
            r = r + den;
         end
         if (2 * r > den) q = q + 1;
         else if (2 * r == den && (q % 2) != 0) q = q + 1;
         y = a + q;
      end
      if (y < 0) y = 0;
      if (y > longint'(LEVEL_MAX)) y = longint'(LEVEL_MAX);
      return LEVEL_W'(y);
   endfunction

   // record the expected level for each accepted pixel
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) owed_levels.push_back(stretch_level(req_gray_in));
   end

   // compare each accepted result with the oldest owed level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_levels.size() == 0) begin
            report_mismatch("unexpected transaction", int'(rsp_gray_out), -1);
         end else begin
            if (rsp_gray_out !== owed_levels[0])
               report_mismatch("gray_out", int'(rsp_gray_out), int'(owed_levels[0]));
            void'(owed_levels.pop_front());
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int wait_cycles;
      rsp_ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         wait_cycles = hold_off_cycles + (take_gaps_on ? $urandom_range(0, 7) : 0);
         hold_off_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // offer one pixel and hold it until accepted
   task automatic send_level(input logic [LEVEL_W-1:0] pix);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_gray_in <= pix;
      do @(posedge clock); while (!req_ready);
   endtask

   // one register access, setup then access cycle; leaves psel high
   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   // write one register with junk in the unused bits, then read it back
   task automatic write_curve_reg(input csr_index_type idx, input logic [7:0] val);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] held;
      wdata = $urandom();
      if (idx == REG_KNEE_COUNT) begin
         wdata[1:0] = val[1:0];
         held = CSR_DATA_W'(val[1:0]);
         curve_knees = val[1:0];
      end else begin
         wdata[7:0] = val;
         held = CSR_DATA_W'(val);
         case (idx)
            REG_KNEE0_IN:  curve_in[0]  = val;
            REG_KNEE0_OUT: curve_out[0] = val;
            REG_KNEE1_IN:  curve_in[1]  = val;
            REG_KNEE1_OUT: curve_out[1] = val;
            REG_KNEE2_IN:  curve_in[2]  = val;
            default:       curve_out[2] = val;
         endcase
      end
      csr_access(1'b1, idx, wdata, rdata);
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== held) report_mismatch(idx.name(), int'(rdata), int'(held));
   endtask

   // wait until the last accepted pixel is owed, then until no level is owed
   task automatic wait_drained();
      @(posedge clock);
      while (owed_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // reprogram the whole curve once the pipeline is empty
   task automatic apply_curve(input logic [1:0] knees,
                              input logic [7:0] in0, input logic [7:0] out0,
                              input logic [7:0] in1, input logic [7:0] out1,
                              input logic [7:0] in2, input logic [7:0] out2);
      req_valid <= 1'b0;
      wait_drained();
      write_curve_reg(REG_KNEE_COUNT, 8'(knees));
      write_curve_reg(REG_KNEE0_IN, in0);
      write_curve_reg(REG_KNEE0_OUT, out0);
      write_curve_reg(REG_KNEE1_IN, in1);
      write_curve_reg(REG_KNEE1_OUT, out1);
      write_curve_reg(REG_KNEE2_IN, in2);
      write_curve_reg(REG_KNEE2_OUT, out2);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // level biased toward the extremes and around the knee inputs, in use or not
   function automatic logic [LEVEL_W-1:0] pick_level();
      int sel;
      int k;
      sel = $urandom_range(0, 11);
      k = $urandom_range(0, KNEE_REGS - 1);
      case (sel)
         0:       return 8'd0;
         1:       return LEVEL_MAX;
         2:       return curve_in[k];
         3:       return curve_in[k] + 8'd1;
         4:       return curve_in[k] - 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // default curve straight after reset
   task automatic test_reset_curve();
      curve_knees  = 2'd1;
      curve_in[0]  = 8'd128;
      curve_out[0] = 8'd128;
      curve_in[1]  = 8'd192;
      curve_out[1] = 8'd192;
      curve_in[2]  = 8'd224;
      curve_out[2] = 8'd224;
      send_level(8'd0);
      send_level(8'd128);
      send_level(8'h55);
      send_level(8'hAA);
      send_level(LEVEL_MAX);
   endtask

   // knee count zero, zero-width segment, rounding ties, unsorted and duplicate knees
   task automatic test_knee_edge_cases();
      // count zero acts as one knee; first knee at zero gives a zero-width segment
      apply_curve(2'd0, 8'd0, 8'd200, 8'd50, 8'd10, 8'd60, 8'd20);
      send_level(8'd0);
      send_level(8'd1);
      send_level(8'd128);
      send_level(LEVEL_MAX);
      // half-way points round to even
      apply_curve(2'd1, 8'd4, 8'd2, 8'd255, 8'd0, 8'd255, 8'd0);
      send_level(8'd1);
      send_level(8'd3);
      send_level(8'd4);
      send_level(8'd170);
      // all three knees, outputs at both extremes
      apply_curve(2'd3, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd255);
      send_level(8'd0);
      send_level(8'd64);
      send_level(8'd200);
      send_level(LEVEL_MAX);
      // knees not ascending
      apply_curve(2'd3, 8'd200, 8'd50, 8'd100, 8'd250, 8'd150, 8'd0);
      send_level(8'd10);
      send_level(8'd150);
      send_level(8'd220);
      send_level(LEVEL_MAX);
      // duplicate knee inputs with two knees in use
      apply_curve(2'd2, 8'd100, 8'd10, 8'd100, 8'd240, 8'd255, 8'd255);
      send_level(8'd99);
      send_level(8'd100);
      send_level(8'd101);
   endtask

   // random curves, mostly ascending, with random pixels
   task automatic test_random_curves();
      logic [7:0] kin [3];
      logic [7:0] kout [3];
      logic [7:0] tmp;
      int         sel;
      for (int phase = 0; phase < 16; phase++) begin
         for (int k = 0; k < 3; k++) begin
            sel = $urandom_range(0, 7);
            kin[k]  = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            sel = $urandom_range(0, 7);
            kout[k] = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 3) != 0) begin
            if (kin[0] > kin[1]) begin tmp = kin[0]; kin[0] = kin[1]; kin[1] = tmp; end
            if (kin[1] > kin[2]) begin tmp = kin[1]; kin[1] = kin[2]; kin[2] = tmp; end
            if (kin[0] > kin[1]) begin tmp = kin[0]; kin[0] = kin[1]; kin[1] = tmp; end
         end
         apply_curve(2'($urandom_range(0, 3)), kin[0], kout[0], kin[1], kout[1],
                     kin[2], kout[2]);
         send_gaps_on = ($urandom_range(0, 3) != 0);
         take_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (55) send_level(pick_level());
      end
   endtask

   // receiver holds off for a long stretch while pixels keep coming
   task automatic test_output_stall();
      apply_curve(2'd3, 8'd40, 8'd10, 8'd120, 8'd200, 8'd230, 8'd240);
      send_gaps_on = 1'b0;
      take_gaps_on = 1'b0;
      hold_off_cycles = 150;
      repeat (60) send_level(8'($urandom_range(0, 255)));
      send_gaps_on = 1'b1;
      take_gaps_on = 1'b1;
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_gray_in <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_curve();
      test_knee_edge_cases();
      test_random_curves();
      test_output_stall();
      req_valid <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && owed_levels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
